>>> src/curve_flat_region_detector_unit_assert.svh
// ----------------------------------------------------------------------------
// curve flat region detector assertion macros
// concurrent checks on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef CURVE_FLAT_REGION_DETECTOR_UNIT_ASSERT_SVH
`define CURVE_FLAT_REGION_DETECTOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define CFRD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
`define CFRD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CFRD_ASSERT(name, prop, msg)
`define CFRD_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

>>> src/cfrd_pkg.sv
// ----------------------------------------------------------------------------
// cfrd_pkg
// types, constants and helpers shared by the flat region detector
// ----------------------------------------------------------------------------
`default_nettype none

package cfrd_pkg;

  localparam int unsigned CoordBits  = 24;
  localparam int unsigned ThreshBits = 10;
  localparam int unsigned ProdBits   = CoordBits + ThreshBits;
  localparam int unsigned Percent    = 100;

  // 8.0 and 10.0 in 16.8 fixed point
  localparam logic [CoordBits-1:0] EndMargin = CoordBits'(8 * 256);
  localparam logic [CoordBits-1:0] SpanMin   = CoordBits'(10 * 256);

  localparam logic [ThreshBits-1:0] ThreshReset = ThreshBits'(25);

  typedef logic signed [CoordBits-1:0] coord_t;

  typedef enum logic {
    OpBegin = 1'b0,
    OpPoint = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    KindHoriz    = 3'd0,
    KindVert     = 3'd1,
    KindYInfl    = 3'd2,
    KindXInfl    = 3'd3,
    KindConflict = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    DirStart = 2'd0,
    DirUp    = 2'd1,
    DirDown  = 2'd2
  } dir_e;

  typedef enum logic [1:0] {
    AxNone     = 2'd0,
    AxResult   = 2'd1,
    AxReversed = 2'd2
  } ax_code_e;

  typedef enum logic [1:0] {
    RegThreshold  = 2'd0,
    RegInflection = 2'd1,
    RegEdit       = 2'd2
  } reg_idx_e;

  typedef struct packed {
    op_e    operation;
    coord_t px;
    coord_t py;
    coord_t end_x;
    coord_t end_y;
  } in_item_t;

  typedef struct packed {
    kind_e  kind;
    coord_t span_from;
    coord_t span_to;
    coord_t location;
    logic   last;
  } out_item_t;

  // decoded command between front and back
  typedef struct packed {
    logic   is_begin;
    coord_t x;
    coord_t y;
    coord_t ex;
    coord_t ey;
  } cmd_t;

  // per axis tracking: run start (main, cross) and run end (main, cross)
  typedef struct packed {
    dir_e   dir;
    dir_e   first;
    logic   flat;
    logic   done;
    coord_t run_m0;
    coord_t run_k0;
    coord_t run_m1;
    coord_t run_k1;
  } axis_state_t;

  typedef struct packed {
    logic [ThreshBits-1:0] threshold;
    logic                  inflection;
    logic                  edit;
  } cfg_t;

  typedef struct packed {
    logic   fire_begin;
    logic   fire_rev;
    logic   tracking_clear;
    coord_t prev_x;
    coord_t prev_y;
  } back_status_t;

  function automatic logic signed [CoordBits:0] sdiff(coord_t a, coord_t b);
    logic signed [CoordBits:0] r;
    r = {a[CoordBits-1], a} - {b[CoordBits-1], b};
    return r;
  endfunction

  function automatic logic [CoordBits-1:0] abs_diff(coord_t a, coord_t b);
    logic signed [CoordBits:0] r;
    r = sdiff(a, b);
    if (r[CoordBits]) begin
      r = -r;
    end
    return r[CoordBits-1:0];
  endfunction

  // (a + b) / 2 truncated toward zero
  function automatic coord_t half_sum(coord_t a, coord_t b);
    logic signed [CoordBits:0] s;
    s = {a[CoordBits-1], a} + {b[CoordBits-1], b};
    s = s + {{CoordBits{1'b0}}, s[CoordBits]};
    return s[CoordBits:1];
  endfunction

endpackage

`default_nettype wire

>>> src/cfrd_front.sv
// ----------------------------------------------------------------------------
// cfrd_front
// accepts input items, decodes them into commands and queues them
// ----------------------------------------------------------------------------
`default_nettype none

module cfrd_front #(
  parameter int unsigned DEPTH = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  cfrd_pkg::in_item_t in_item_i,
  output logic               in_stall_o,
  output logic               cmd_valid_o,
  output cfrd_pkg::cmd_t     cmd_o,
  input  logic               cmd_take_i
);
  import cfrd_pkg::*;

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  cmd_t            q_mem [DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            full, push, pop;
  cmd_t            cmd_in;

  assign full        = (cnt_q == CntW'(DEPTH));
  assign in_stall_o  = full;
  assign push        = in_valid_i && !full;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = cmd_take_i && cmd_valid_o;
  assign cmd_o       = q_mem[rd_q];

  always_comb begin
    cmd_in.is_begin = (in_item_i.operation == OpBegin);
    cmd_in.x        = in_item_i.px;
    cmd_in.y        = in_item_i.py;
    cmd_in.ex       = in_item_i.end_x;
    cmd_in.ey       = in_item_i.end_y;
  end

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_q] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

>>> src/cfrd_axis.sv
// ----------------------------------------------------------------------------
// cfrd_axis
// one axis step: direction tracking, flatness test and run end checks
// ----------------------------------------------------------------------------
`default_nettype none

module cfrd_axis (
  input  cfrd_pkg::axis_state_t              cur_i,
  input  cfrd_pkg::coord_t                   m_i,
  input  cfrd_pkg::coord_t                   k_i,
  input  cfrd_pkg::coord_t                   pm_i,
  input  cfrd_pkg::coord_t                   pk_i,
  input  cfrd_pkg::coord_t                   e0_i,
  input  cfrd_pkg::coord_t                   e1_i,
  input  logic [cfrd_pkg::ThreshBits-1:0]    thresh_i,
  output cfrd_pkg::axis_state_t              nxt_o,
  output cfrd_pkg::ax_code_e                 code_o,
  output cfrd_pkg::coord_t                   from_o,
  output cfrd_pkg::coord_t                   to_o,
  output cfrd_pkg::coord_t                   loc_o
);
  import cfrd_pkg::*;

  dir_e                nd;
  logic [ProdBits-1:0] n, d;
  axis_state_t         nxt;
  ax_code_e            code;
  logic                near_end, backward, wide;

  always_comb begin
    if (m_i > pm_i) begin
      nd = DirUp;
    end else if (m_i < pm_i) begin
      nd = DirDown;
    end else begin
      nd = DirStart;
    end
  end

  // steepness along vs across, scaled by percent and threshold
  assign n = ProdBits'(abs_diff(m_i, pm_i)) * ProdBits'(Percent);
  assign d = ProdBits'(abs_diff(k_i, pk_i)) * ProdBits'(thresh_i);

  always_comb begin
    nxt      = cur_i;
    code     = AxNone;
    near_end = 1'b0;
    backward = 1'b0;
    wide     = 1'b0;
    if (nd != DirStart && cur_i.dir != nd) begin
      if (cur_i.dir == DirStart) begin
        nxt.dir   = nd;
        nxt.first = nd;
      end else begin
        if (cur_i.first == nd) begin
          nxt.run_m1 = pm_i;
          nxt.run_k1 = pk_i;
        end else if (!cur_i.flat) begin
          nxt.run_m0 = pm_i;
          nxt.run_k0 = pk_i;
          nxt.flat   = 1'b1;
        end
        nxt.dir = nd;
      end
    end
    if (!nxt.flat) begin
      if (n < d) begin
        nxt.flat   = 1'b1;
        nxt.run_m0 = pm_i;
        nxt.run_k0 = pk_i;
      end
    end else if (nxt.dir == nxt.first) begin
      if (n > d) begin
        nxt.run_m1 = pm_i;
        nxt.run_k1 = pk_i;
        nxt.done   = 1'b1;
      end
      near_end = (abs_diff(nxt.run_m0, e0_i) <= EndMargin) ||
                 (abs_diff(e1_i, nxt.run_m1) <= EndMargin);
      backward = (nxt.first == DirUp &&
                  sdiff(nxt.run_m0, nxt.run_m1) > $signed({1'b0, EndMargin})) ||
                 (nxt.first == DirDown &&
                  sdiff(nxt.run_m1, nxt.run_m0) > $signed({1'b0, EndMargin}));
      wide     = abs_diff(nxt.run_k0, nxt.run_k1) > SpanMin;
      if (nxt.done && !near_end) begin
        if (backward) begin
          code = AxReversed;
        end else if (wide) begin
          code = AxResult;
        end
      end
    end
  end

  assign nxt_o  = nxt;
  assign code_o = code;
  assign from_o = nxt.run_k0;
  assign to_o   = nxt.run_k1;
  assign loc_o  = half_sum(nxt.run_m0, nxt.run_m1);

endmodule

`default_nettype wire

>>> src/cfrd_back.sv
// ----------------------------------------------------------------------------
// cfrd_back
// executes queued commands on the curve state and forms result items
// ----------------------------------------------------------------------------
`default_nettype none

module cfrd_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cmd_valid_i,
  input  cfrd_pkg::cmd_t         cmd_i,
  output logic                   cmd_take_o,
  input  cfrd_pkg::cfg_t         cfg_i,
  input  logic                   room_i,
  output logic [1:0]             push_n_o,
  output cfrd_pkg::out_item_t    push_a_o,
  output cfrd_pkg::out_item_t    push_b_o,
  output cfrd_pkg::back_status_t status_o
);
  import cfrd_pkg::*;

  axis_state_t y_q, y_d, x_q, x_d, y_nxt, x_nxt;
  coord_t      prev_x_q, prev_x_d, prev_y_q, prev_y_d;
  coord_t      sx_q, sx_d, sy_q, sy_d, ex_q, ex_d, ey_q, ey_d;
  ax_code_e    y_code, x_code;
  coord_t      y_from, y_to, y_loc, x_from, x_to, x_loc;
  logic        fire, rev, conflict_en;
  logic [1:0]  n_res;
  out_item_t   res_a, res_b, y_item, x_item, c_item;

  assign fire        = cmd_valid_i && room_i;
  assign cmd_take_o  = fire;
  assign conflict_en = cfg_i.edit && !cfg_i.inflection;

  cfrd_axis u_axis_y (
    .cur_i    (y_q),
    .m_i      (cmd_i.y),
    .k_i      (cmd_i.x),
    .pm_i     (prev_y_q),
    .pk_i     (prev_x_q),
    .e0_i     (sy_q),
    .e1_i     (ey_q),
    .thresh_i (cfg_i.threshold),
    .nxt_o    (y_nxt),
    .code_o   (y_code),
    .from_o   (y_from),
    .to_o     (y_to),
    .loc_o    (y_loc)
  );

  cfrd_axis u_axis_x (
    .cur_i    (x_q),
    .m_i      (cmd_i.x),
    .k_i      (cmd_i.y),
    .pm_i     (prev_x_q),
    .pk_i     (prev_y_q),
    .e0_i     (sx_q),
    .e1_i     (ex_q),
    .thresh_i (cfg_i.threshold),
    .nxt_o    (x_nxt),
    .code_o   (x_code),
    .from_o   (x_from),
    .to_o     (x_to),
    .loc_o    (x_loc)
  );

  always_comb begin
    y_item.kind      = cfg_i.inflection ? KindYInfl : KindHoriz;
    y_item.span_from = y_from;
    y_item.span_to   = y_to;
    y_item.location  = y_loc;
    y_item.last      = 1'b0;
    x_item.kind      = cfg_i.inflection ? KindXInfl : KindVert;
    x_item.span_from = x_from;
    x_item.span_to   = x_to;
    x_item.location  = x_loc;
    x_item.last      = 1'b0;
    c_item           = '0;
    c_item.kind      = KindConflict;
  end

  always_comb begin
    y_d      = y_q;
    x_d      = x_q;
    prev_x_d = prev_x_q;
    prev_y_d = prev_y_q;
    sx_d     = sx_q;
    sy_d     = sy_q;
    ex_d     = ex_q;
    ey_d     = ey_q;
    rev      = 1'b0;
    n_res    = 2'd0;
    res_a    = '0;
    res_b    = '0;
    if (fire) begin
      if (cmd_i.is_begin) begin
        y_d      = '0;
        x_d      = '0;
        sx_d     = cmd_i.x;
        sy_d     = cmd_i.y;
        ex_d     = cmd_i.ex;
        ey_d     = cmd_i.ey;
        prev_x_d = cmd_i.x;
        prev_y_d = cmd_i.y;
      end else begin
        if (!y_q.done) begin
          y_d = y_nxt;
          if (y_code == AxReversed) begin
            rev = 1'b1;
            if (conflict_en) begin
              res_a = c_item;
              n_res = 2'd1;
            end
          end else if (y_code == AxResult) begin
            res_a = y_item;
            n_res = 2'd1;
          end
        end
        // a reversed y run skips the x axis
        if (!rev && !x_q.done) begin
          x_d = x_nxt;
          if (x_code == AxReversed) begin
            rev = 1'b1;
            if (conflict_en) begin
              if (n_res == 2'd0) begin
                res_a = c_item;
              end else begin
                res_b = c_item;
              end
              n_res = n_res + 2'd1;
            end
          end else if (x_code == AxResult) begin
            if (n_res == 2'd0) begin
              res_a = x_item;
            end else begin
              res_b = x_item;
            end
            n_res = n_res + 2'd1;
          end
        end
        if (!rev) begin
          prev_x_d = cmd_i.x;
          prev_y_d = cmd_i.y;
        end
      end
    end
    if (n_res == 2'd1) begin
      res_a.last = 1'b1;
    end
    if (n_res == 2'd2) begin
      res_b.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      y_q      <= '0;
      x_q      <= '0;
      prev_x_q <= '0;
      prev_y_q <= '0;
      sx_q     <= '0;
      sy_q     <= '0;
      ex_q     <= '0;
      ey_q     <= '0;
    end else begin
      y_q      <= y_d;
      x_q      <= x_d;
      prev_x_q <= prev_x_d;
      prev_y_q <= prev_y_d;
      sx_q     <= sx_d;
      sy_q     <= sy_d;
      ex_q     <= ex_d;
      ey_q     <= ey_d;
    end
  end

  assign push_n_o = n_res;
  assign push_a_o = res_a;
  assign push_b_o = res_b;

  always_comb begin
    status_o.fire_begin     = fire && cmd_i.is_begin;
    status_o.fire_rev       = fire && !cmd_i.is_begin && rev;
    status_o.tracking_clear = (y_q.dir == DirStart) && (y_q.first == DirStart) &&
                              !y_q.flat && !y_q.done &&
                              (x_q.dir == DirStart) && (x_q.first == DirStart) &&
                              !x_q.flat && !x_q.done;
    status_o.prev_x         = prev_x_q;
    status_o.prev_y         = prev_y_q;
  end

endmodule

`default_nettype wire

>>> src/cfrd_res_queue.sv
// ----------------------------------------------------------------------------
// cfrd_res_queue
// result queue taking up to two items a cycle and giving one a cycle while out_stall_i is low
// ----------------------------------------------------------------------------
`default_nettype none

module cfrd_res_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          push_n_i,
  input  cfrd_pkg::out_item_t push_a_i,
  input  cfrd_pkg::out_item_t push_b_i,
  output logic                room_o,
  output logic                out_valid_o,
  output cfrd_pkg::out_item_t out_item_o,
  input  logic                out_stall_i
);
  import cfrd_pkg::*;

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  out_item_t       q_mem [DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, wr1, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  // room for the worst case of two results
  assign room_o      = (cnt_q <= CntW'(DEPTH - 2));
  assign out_valid_o = (cnt_q != '0);
  assign out_item_o  = q_mem[rd_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign wr1         = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    if (push_n_i == 2'd1) begin
      wr_d = wr1;
    end else if (push_n_i == 2'd2) begin
      wr_d = (wr1 == PtrW'(DEPTH - 1)) ? '0 : wr1 + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    cnt_d = cnt_q + CntW'(push_n_i) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      q_mem[wr_q] <= push_a_i;
    end
    if (push_n_i == 2'd2) begin
      q_mem[wr1] <= push_b_i;
    end
  end

endmodule

`default_nettype wire

>>> src/curve_flat_region_detector_unit.sv
// ----------------------------------------------------------------------------
// curve_flat_region_detector_unit
// finds flat runs in the flattened points of one cubic curve
// ----------------------------------------------------------------------------
// in channel: in_valid_i / in_stall_o carry begin and point items. a begin
// item latches the curve ends and clears tracking; a point item may give up
// to two result items on the out channel (out_valid_o / out_stall_i), the
// final one flagged by last.
// a front queue of QUEUE_DEPTH commands feeds the back end, which executes
// one command a cycle; results pass through a queue of QUEUE_DEPTH entries.
// an accepted item is registered in the front queue, executed by the back end
// and its results registered in the result queue before the first can be taken.
// throughput: one item per cycle while items give at most one result each.
// the back end waits whenever the result queue has fewer than two free
// entries, so two-result items move only as fast as results leave, one per cycle.
// when the receiver stalls, results collect in the result queue, then the
// back end halts and the front queue fills until in_stall_o rises.
// reset clears all curve state and queues; tangent_threshold resets to 25,
// inflection_mode to 0, edit_enable to 1. config regs at byte 0, 4, 8.
// ----------------------------------------------------------------------------
`default_nettype none

`include "curve_flat_region_detector_unit_assert.svh"

module curve_flat_region_detector_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  cfrd_pkg::in_item_t  in_item_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  output cfrd_pkg::out_item_t out_item_o,
  input  logic                out_stall_i,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import cfrd_pkg::*;

  logic [ThreshBits-1:0] thresh_q;
  logic                  infl_q, edit_q;
  logic [1:0]            reg_idx;
  logic                  cfg_we;
  cfg_t                  cfg;

  logic                  cmd_valid, cmd_take, room;
  cmd_t                  cmd;
  logic [1:0]            push_n;
  out_item_t             push_a, push_b;
  back_status_t          st;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= ThreshReset;
      infl_q   <= 1'b0;
      edit_q   <= 1'b1;
    end else if (cfg_we) begin
      unique case (reg_idx)
        RegThreshold:  thresh_q <= pwdata[ThreshBits-1:0];
        RegInflection: infl_q   <= pwdata[0];
        RegEdit:       edit_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegThreshold:  prdata = {{(32 - ThreshBits){1'b0}}, thresh_q};
      RegInflection: prdata = {31'b0, infl_q};
      RegEdit:       prdata = {31'b0, edit_q};
      default:       prdata = '0;
    endcase
  end

  always_comb begin
    cfg.threshold  = thresh_q;
    cfg.inflection = infl_q;
    cfg.edit       = edit_q;
  end

  cfrd_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_item_i),
    .in_stall_o  (in_stall_o),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_take_i  (cmd_take)
  );

  cfrd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_take_o  (cmd_take),
    .cfg_i       (cfg),
    .room_i      (room),
    .push_n_o    (push_n),
    .push_a_o    (push_a),
    .push_b_o    (push_b),
    .status_o    (st)
  );

  cfrd_res_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_res_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_n_i    (push_n),
    .push_a_i    (push_a),
    .push_b_i    (push_b),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .out_stall_i (out_stall_i)
  );

  `CFRD_ASSERT_NEXT(a_begin_clears, st.fire_begin, st.tracking_clear,
                    "begin left tracking set")
  `CFRD_ASSERT_NEXT(a_rev_keeps_prev, st.fire_rev,
                    $stable(st.prev_x) && $stable(st.prev_y),
                    "reversed run moved previous point")
  `CFRD_ASSERT(a_conflict_zero,
               (out_valid_o && out_item_o.kind == KindConflict) |->
                 (out_item_o.span_from == '0 && out_item_o.span_to == '0 &&
                  out_item_o.location == '0 && out_item_o.last),
               "conflict item malformed")

endmodule

`default_nettype wire

>>> tb/tb_curve_flat_region_detector_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_curve_flat_region_detector_unit
// drives flattened curve points into the flat region detector and checks
// every result item against a cycle-free model of the detector, with random
// idling on both channels and several register settings written over apb
// ----------------------------------------------------------------------------

module tb_curve_flat_region_detector_unit;
  import cfrd_pkg::*;

  localparam int unsigned SettleCycles   = 24;
  localparam int unsigned MaxReported    = 10;
  localparam int unsigned LongHoldCycles = 400;
  localparam int unsigned PhaseItems     = 153;
  localparam int unsigned Phases         = 10;
  localparam longint      TimeoutNs      = 2_000_000;
  localparam longint      CoordMin       = -(longint'(1) << (CoordBits - 1));
  localparam longint      CoordMax       = (longint'(1) << (CoordBits - 1)) - 1;

  typedef enum int {
    ShapeStair,
    ShapeZigzag,
    ShapeWalk,
    ShapeNoise
  } shape_e;

  logic        clk      = 1'b0;
  logic        rst_n    = 1'b0;
  logic        in_valid = 1'b0;
  in_item_t    in_item  = '0;
  logic        in_stall;
  logic        out_valid;
  out_item_t   out_item;
  logic        out_stall = 1'b0;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [3:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  // register copies and curve tracking as the detector should hold them
  logic [ThreshBits-1:0] cfg_threshold = ThreshReset;
  logic                  cfg_inflection = 1'b0;
  logic                  cfg_edit       = 1'b1;
  axis_state_t           y_track = '0;
  axis_state_t           x_track = '0;
  coord_t                last_x = '0, last_y = '0;
  coord_t                curve_x0 = '0, curve_y0 = '0, curve_x1 = '0, curve_y1 = '0;

  in_item_t    curve_items[$];
  out_item_t   awaited_results[$];
  longint      walk_main[$], walk_cross[$];
  int unsigned queued_total = 0;
  int unsigned sent_total   = 0;
  int unsigned error_count  = 0;
  int unsigned gap_left = 0, burst_left = 0;
  int unsigned hold_left = 0, mode_left = 0, stall_pct = 0;
  logic        long_hold_req   = 1'b0;
  logic        long_hold_taken = 1'b0;

  curve_flat_region_detector_unit i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_item_i   (in_item),
    .in_stall_o  (in_stall),
    .out_valid_o (out_valid),
    .out_item_o  (out_item),
    .out_stall_i (out_stall),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void flag_error(string msg);
    error_count++;
    if (error_count <= MaxReported) begin
      $display("%s", msg);
    end
  endfunction

  function automatic longint wide(coord_t v);
    return v;
  endfunction

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint rnd(longint lo, longint hi);
    return lo + longint'($urandom_range(0, 32'(hi - lo)));
  endfunction

  function automatic out_item_t make_result(kind_e kind, coord_t from_c, coord_t to_c,
                                            coord_t loc);
    out_item_t r;
    r = '0;
    r.kind      = kind;
    r.span_from = from_c;
    r.span_to   = to_c;
    r.location  = loc;
    return r;
  endfunction

  // one axis: m/k main and cross coordinate, pm/pk the previous point,
  // e0/e1 the curve ends along the main axis
  function automatic ax_code_e track_axis(inout axis_state_t s, input coord_t m,
                                          input coord_t k, input coord_t pm,
                                          input coord_t pk, input coord_t e0,
                                          input coord_t e1, output coord_t from_c,
                                          output coord_t to_c, output coord_t loc);
    dir_e   step_dir;
    longint n, d, margin;
    from_c = '0;
    to_c   = '0;
    loc    = '0;
    margin = longint'(EndMargin);
    if (m > pm) begin
      step_dir = DirUp;
    end else if (m < pm) begin
      step_dir = DirDown;
    end else begin
      step_dir = DirStart;
    end
    if (step_dir != DirStart && s.dir != step_dir) begin
      if (s.dir == DirStart) begin
        s.dir   = step_dir;
        s.first = step_dir;
      end else begin
        // turning back toward the first direction closes the run,
        // turning away from it opens one
        if (s.first == step_dir) begin
          s.run_m1 = pm;
          s.run_k1 = pk;
        end else if (!s.flat) begin
          s.run_m0 = pm;
          s.run_k0 = pk;
          s.flat   = 1'b1;
        end
        s.dir = step_dir;
      end
    end
    n = mag(wide(m) - wide(pm)) * longint'(Percent);
    d = mag(wide(k) - wide(pk)) * longint'(cfg_threshold);
    if (!s.flat) begin
      if (n < d) begin
        s.flat   = 1'b1;
        s.run_m0 = pm;
        s.run_k0 = pk;
      end
      return AxNone;
    end
    if (s.dir != s.first) begin
      return AxNone;
    end
    if (n > d) begin
      s.run_m1 = pm;
      s.run_k1 = pk;
      s.done   = 1'b1;
    end
    if (!s.done) begin
      return AxNone;
    end
    if (mag(wide(s.run_m0) - wide(e0)) <= margin ||
        mag(wide(e1) - wide(s.run_m1)) <= margin) begin
      return AxNone;
    end
    if ((s.first == DirUp && wide(s.run_m0) - wide(s.run_m1) > margin) ||
        (s.first == DirDown && wide(s.run_m1) - wide(s.run_m0) > margin)) begin
      return AxReversed;
    end
    if (mag(wide(s.run_k0) - wide(s.run_k1)) > longint'(SpanMin)) begin
      from_c = s.run_k0;
      to_c   = s.run_k1;
      loc    = coord_t'((wide(s.run_m0) + wide(s.run_m1)) / 2);
      return AxResult;
    end
    return AxNone;
  endfunction

  // advance the curve tracking by one accepted item and queue its results
  function automatic void find_flat_runs(in_item_t it);
    out_item_t found[$];
    ax_code_e  code;
    coord_t    from_c, to_c, loc;
    logic      reversed;
    if (it.operation == OpBegin) begin
      y_track  = '0;
      x_track  = '0;
      curve_x0 = it.px;
      curve_y0 = it.py;
      curve_x1 = it.end_x;
      curve_y1 = it.end_y;
      last_x   = it.px;
      last_y   = it.py;
      return;
    end
    reversed = 1'b0;
    if (!y_track.done) begin
      code = track_axis(y_track, it.py, it.px, last_y, last_x, curve_y0, curve_y1,
                        from_c, to_c, loc);
      if (code == AxReversed) begin
        reversed = 1'b1;
      end else if (code == AxResult) begin
        if (cfg_inflection) begin
          found.push_back(make_result(KindYInfl, from_c, to_c, loc));
        end else begin
          found.push_back(make_result(KindHoriz, from_c, to_c, loc));
        end
      end
    end
    if (!reversed && !x_track.done) begin
      code = track_axis(x_track, it.px, it.py, last_x, last_y, curve_x0, curve_x1,
                        from_c, to_c, loc);
      if (code == AxReversed) begin
        reversed = 1'b1;
      end else if (code == AxResult) begin
        if (cfg_inflection) begin
          found.push_back(make_result(KindXInfl, from_c, to_c, loc));
        end else begin
          found.push_back(make_result(KindVert, from_c, to_c, loc));
        end
      end
    end
    if (reversed) begin
      // previous point stays where it was
      if (cfg_edit && !cfg_inflection) begin
        found.push_back(make_result(KindConflict, '0, '0, '0));
      end
    end else begin
      last_x = it.px;
      last_y = it.py;
    end
    if (found.size() > 0) begin
      found[found.size() - 1].last = 1'b1;
    end
    foreach (found[i]) begin
      awaited_results.push_back(found[i]);
    end
  endfunction

  function automatic void queue_begin(longint sx, longint sy, longint ex, longint ey);
    in_item_t it;
    it.operation = OpBegin;
    it.px        = coord_t'(sx);
    it.py        = coord_t'(sy);
    it.end_x     = coord_t'(ex);
    it.end_y     = coord_t'(ey);
    curve_items.push_back(it);
    queued_total++;
  endfunction

  function automatic void queue_point(longint x, longint y);
    in_item_t it;
    it.operation = OpPoint;
    it.px        = coord_t'(x);
    it.py        = coord_t'(y);
    it.end_x     = coord_t'($urandom);
    it.end_y     = coord_t'($urandom);
    curve_items.push_back(it);
    queued_total++;
  endfunction

  function automatic void add_leg(int unsigned steps, longint main_lo, longint main_hi,
                                  longint cross_lo, longint cross_hi);
    longint a, b;
    repeat (steps) begin
      a = walk_main[walk_main.size() - 1];
      b = walk_cross[walk_cross.size() - 1];
      // now and then the point does not move at all
      if ($urandom_range(0, 9) != 0) begin
        a += rnd(main_lo, main_hi);
        b += rnd(cross_lo, cross_hi);
      end
      walk_main.push_back(a);
      walk_cross.push_back(b);
    end
  endfunction

  // one curve: a walk in local coordinates (main rises steeply, cross runs
  // along the flat stretches), then swapped, mirrored and moved at random
  function automatic void add_curve(shape_e shape);
    longint      lo_x, hi_x, lo_y, hi_y, ox, oy, x, y;
    logic        swap_ax, flip_x, flip_y;
    int unsigned last_idx;
    if (shape == ShapeNoise) begin
      if ($urandom_range(0, 1) != 0) begin
        queue_begin(wide(coord_t'($urandom)), wide(coord_t'($urandom)),
                    wide(coord_t'($urandom)), wide(coord_t'($urandom)));
      end
      repeat ($urandom_range(1, 4)) begin
        queue_point(wide(coord_t'($urandom)), wide(coord_t'($urandom)));
      end
      return;
    end
    walk_main.delete();
    walk_cross.delete();
    walk_main.push_back(0);
    walk_cross.push_back(0);
    case (shape)
      ShapeStair: begin
        add_leg($urandom_range(1, 4), 300, 3000, -40, 40);
        repeat ($urandom_range(1, 2)) begin
          add_leg($urandom_range(1, 6), -8, 40, 200, 2500);
          add_leg($urandom_range(1, 4), 300, 3000, -40, 40);
        end
      end
      ShapeZigzag: begin
        add_leg($urandom_range(1, 3), 300, 3000, -40, 40);
        add_leg($urandom_range(1, 3), -3000, -300, -40, 40);
        add_leg($urandom_range(1, 3), 300, 3000, -40, 40);
        if ($urandom_range(0, 1) != 0) begin
          add_leg($urandom_range(1, 4), -8, 40, 200, 2500);
        end
        add_leg($urandom_range(1, 3), 300, 3000, -40, 40);
      end
      default: begin
        add_leg($urandom_range(3, 12), -3000, 3000, -3000, 3000);
      end
    endcase
    // curve end point goes last, mostly just past the final point
    last_idx = walk_main.size() - 1;
    if ($urandom_range(0, 3) != 0) begin
      walk_main.push_back(walk_main[last_idx] + rnd(-300, 300));
      walk_cross.push_back(walk_cross[last_idx] + rnd(-300, 300));
    end else begin
      walk_main.push_back(rnd(-3000, 3000));
      walk_cross.push_back(rnd(-3000, 3000));
    end
    swap_ax = 1'($urandom_range(0, 1));
    flip_x  = 1'($urandom_range(0, 1));
    flip_y  = 1'($urandom_range(0, 1));
    lo_x = 0;
    hi_x = 0;
    lo_y = 0;
    hi_y = 0;
    foreach (walk_main[i]) begin
      x = swap_ax ? walk_cross[i] : walk_main[i];
      y = swap_ax ? walk_main[i] : walk_cross[i];
      if (flip_x) x = -x;
      if (flip_y) y = -y;
      walk_main[i]  = x;
      walk_cross[i] = y;
      if (x < lo_x) lo_x = x;
      if (x > hi_x) hi_x = x;
      if (y < lo_y) lo_y = y;
      if (y > hi_y) hi_y = y;
    end
    ox = rnd(CoordMin - lo_x, CoordMax - hi_x);
    oy = rnd(CoordMin - lo_y, CoordMax - hi_y);
    // push some curves right against the edges of the coordinate range
    if ($urandom_range(0, 7) == 0) begin
      ox = $urandom_range(0, 1) ? CoordMin - lo_x : CoordMax - hi_x;
    end
    if ($urandom_range(0, 7) == 0) begin
      oy = $urandom_range(0, 1) ? CoordMin - lo_y : CoordMax - hi_y;
    end
    last_idx = walk_main.size() - 1;
    queue_begin(walk_main[0] + ox, walk_cross[0] + oy,
                walk_main[last_idx] + ox, walk_cross[last_idx] + oy);
    for (int unsigned i = 1; i < last_idx; i++) begin
      queue_point(walk_main[i] + ox, walk_cross[i] + oy);
    end
  endfunction

  // sender: bursts of random length separated by random gaps
  always @(posedge clk) begin : send_items
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        find_flat_runs(in_item);
        sent_total++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (curve_items.size() > 0) begin
          in_item  <= curve_items.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall rate changes every so often, plus one long hold-off
  always @(posedge clk) begin : stall_results
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (long_hold_req && !long_hold_taken) begin
        long_hold_taken = 1'b1;
        hold_left       = LongHoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left > 0) begin
          mode_left--;
        end else begin
          mode_left = $urandom_range(16, 200);
          stall_pct = $urandom_range(0, 3) * 28;
        end
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        flag_error($sformatf("unexpected result: kind %0d from %0d to %0d loc %0d last %0d",
                             out_item.kind, out_item.span_from, out_item.span_to,
                             out_item.location, out_item.last));
      end else begin
        want = awaited_results.pop_front();
        if (out_item.kind !== want.kind || out_item.span_from !== want.span_from ||
            out_item.span_to !== want.span_to || out_item.location !== want.location ||
            out_item.last !== want.last) begin
          flag_error($sformatf({"result mismatch: expected kind %0d from %0d to %0d loc %0d",
                                " last %0d, got kind %0d from %0d to %0d loc %0d last %0d"},
                               want.kind, want.span_from, want.span_to, want.location,
                               want.last, out_item.kind, out_item.span_from,
                               out_item.span_to, out_item.location, out_item.last));
        end
      end
    end
  end

  // write one register, then read it back
  task automatic write_reg(reg_idx_e idx, logic [31:0] value);
    logic [31:0] kept;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegThreshold: begin
        cfg_threshold = value[ThreshBits-1:0];
        kept          = 32'(cfg_threshold);
      end
      RegInflection: begin
        cfg_inflection = value[0];
        kept           = 32'(cfg_inflection);
      end
      RegEdit: begin
        cfg_edit = value[0];
        kept     = 32'(cfg_edit);
      end
      default: begin
        kept = '0;
      end
    endcase
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (prdata !== kept) begin
      flag_error($sformatf("register %0d read back: expected %0d, got %0d", idx, kept, prdata));
    end
  endtask

  task automatic wait_idle(int unsigned settle);
    while (sent_total != queued_total || awaited_results.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  initial begin : run_test
    int unsigned phase_end;
    int unsigned pick;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // points before any curve, then extreme coordinates
    queue_point(300, 9000);
    queue_point(CoordMin, CoordMax);
    queue_begin(CoordMin, CoordMax, CoordMax, CoordMin);
    queue_point(CoordMax, CoordMin);
    queue_point(CoordMax, CoordMin);
    // horizontal flat run between two climbs
    queue_begin(0, 0, 3000, 12000);
    queue_point(0, 3000);
    queue_point(0, 6000);
    queue_point(1000, 6000);
    queue_point(2000, 6000);
    queue_point(3000, 6000);
    queue_point(3000, 9000);
    // the same with the axes swapped
    queue_begin(0, 0, 12000, 3000);
    queue_point(3000, 0);
    queue_point(6000, 0);
    queue_point(6000, 1000);
    queue_point(6000, 2000);
    queue_point(6000, 3000);
    queue_point(9000, 3000);
    // climb, fall back and climb again: a reversed run
    queue_begin(0, 0, 0, 20000);
    queue_point(0, 4000);
    queue_point(0, 8000);
    queue_point(100, 3000);
    queue_point(200, 9000);
    wait_idle(SettleCycles);

    for (int unsigned phase = 0; phase < Phases; phase++) begin
      case (phase)
        0: begin
          write_reg(RegThreshold, 0);
          write_reg(RegInflection, 0);
          write_reg(RegEdit, 1);
        end
        1: write_reg(RegThreshold, 1000);
        2: begin
          write_reg(RegThreshold, 25);
          write_reg(RegInflection, 1);
        end
        3: begin
          write_reg(RegInflection, 0);
          write_reg(RegEdit, 0);
        end
        4: begin
          write_reg(RegThreshold, 1000);
          write_reg(RegInflection, 1);
        end
        default: begin
          write_reg(RegThreshold, 32'(rnd(0, 1000)));
          write_reg(RegInflection, 32'($urandom_range(0, 2) == 0));
          write_reg(RegEdit, $urandom_range(0, 1));
        end
      endcase
      // receiver holds off for a long stretch while items keep coming
      if (phase == 2) long_hold_req = 1'b1;
      phase_end = queued_total + PhaseItems;
      while (queued_total < phase_end) begin
        // halfway through one phase the sender waits for all results
        if (phase == 6 && queued_total + PhaseItems / 2 >= phase_end &&
            queued_total + PhaseItems / 2 < phase_end + 4) begin
          wait_idle(0);
        end
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
          add_curve(ShapeStair);
        end else if (pick < 7) begin
          add_curve(ShapeZigzag);
        end else if (pick < 8) begin
          add_curve(ShapeWalk);
        end else begin
          add_curve(ShapeNoise);
        end
      end
      wait_idle(SettleCycles);
    end

    if (error_count == 0 && awaited_results.size() == 0) begin
      $display("** curve_flat_region_detector_unit: PASSED **");
    end else begin
      $display("** curve_flat_region_detector_unit: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #(TimeoutNs);
    $display("** curve_flat_region_detector_unit: FAILED **");
    $finish;
  end

endmodule
